/* design/text_mode_console_writer_defines.svh */
// Assertion macros shared by the console writer RTL.
// Included by the controller and datapath; depends on nothing else.
`ifndef TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TMCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TMCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/tmcw_pkg.sv */
// Shared types and constants of the console writer.
// Used by the datapath, controller and top level; depends on nothing.
`default_nettype none

package tmcw_pkg;

   localparam int CHAR_W      = 8;
   localparam int CELL_W      = 16;
   localparam int INDEX_W     = 11;
   localparam int COL_OUT_W   = 7;
   localparam int ROW_OUT_W   = 5;

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_FIELD_W = COL_OUT_W + ROW_OUT_W + 1 + CELL_W;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CHAR_W-1:0] NUL_CHAR     = 8'h00;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
   localparam logic [CELL_W-1:0] ATTR_MASK    = 16'hFF00;

   typedef enum logic [1:0] {
      RD_ITEM,
      RD_CURSOR,
      RD_SWEEP
   } rd_sel_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_NEWLINE,
      CUR_ADVANCE,
      CUR_HOME
   } cur_op_type;

   typedef enum logic [1:0] {
      OUT_PUT,
      OUT_READ,
      OUT_CLEAR
   } out_kind_type;

   typedef struct packed {
      logic         latch_item;
      logic         rd_en;
      rd_sel_type   rd_sel;
      cur_op_type   cur_op;
      logic         wr_put;
      logic         init_wr;
      logic         sweep_clear;
      logic         sweep_step;
      logic         out_load;
      out_kind_type out_kind;
   } ctl_cmd_type;

   typedef struct packed {
      logic req_is_read;
      logic req_char_zero;
      logic req_char_newline;
      logic last_row;
      logic last_col;
      logic sweep_done;
      logic rsp_free;
   } ctl_status_type;

endpackage

`default_nettype wire

/* design/tmcw_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the cell store; depends on nothing.
`default_nettype none

module tmcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* design/tmcw_datapath.sv */
// Datapath of the console writer: cursor, sweep pointer, cell store and result register.
// Depends on tmcw_pkg, tmcw_ram and the shared assertion macros.
`default_nettype none
`include "text_mode_console_writer_defines.svh"

module tmcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tmcw_pkg::ctl_cmd_type             cmd,
   output      tmcw_pkg::ctl_status_type          status,
   input  wire logic [tmcw_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic [tmcw_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [tmcw_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import tmcw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);

   logic [CHAR_W-1:0]    req_char;
   logic [INDEX_W-1:0]   req_index;
   logic [CMP_W-1:0]     req_index_ext;
   logic                 req_in_range;

   logic [CHAR_W-1:0]    char_ff;
   logic                 in_range_ff;

   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ADDR_W-1:0]    cursor_pos;

   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic                 wr_pend_ff;
   logic [ADDR_W-1:0]    wr_addr_ff;

   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [CELL_W-1:0]    ram_wr_data;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [CELL_W-1:0]    ram_rd_data;

   logic                 rsp_valid_ff;
   logic [COL_OUT_W-1:0] rsp_col_ff;
   logic [ROW_OUT_W-1:0] rsp_row_ff;
   logic                 rsp_cleared_ff;
   logic [CELL_W-1:0]    rsp_cell_ff;

   assign req_char      = req_tdata[CHAR_W-1:0];
   assign req_index     = req_tdata[CHAR_W +: INDEX_W];
   assign req_index_ext = CMP_W'(req_index);
   assign req_in_range  = req_index_ext < CMP_W'(CELLS);

   assign cursor_pos = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(COLUMNS)) + ADDR_W'(col_ff);

   // Cursor update
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      case (cmd.cur_op)
         CUR_HOLD: begin
         end
         CUR_NEWLINE: begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end
         CUR_ADVANCE: begin
            if (status.last_col) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         CUR_HOME: begin
            col_in = '0;
            row_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.sweep_clear) begin
         ptr_in = '0;
      end else if (cmd.sweep_step || cmd.init_wr) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
   end

   // Read port
   always_comb begin
      case (cmd.rd_sel)
         RD_ITEM:   ram_rd_addr = req_index_ext[ADDR_W-1:0];
         RD_CURSOR: ram_rd_addr = cursor_pos;
         RD_SWEEP:  ram_rd_addr = ptr_ff[ADDR_W-1:0];
         default:   ram_rd_addr = cursor_pos;
      endcase
   end

   // Write port: clearing pass, blanking write-back, or character put
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cursor_pos;
      ram_wr_data = BLANK_CELL;
      if (cmd.init_wr) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = ptr_ff[ADDR_W-1:0];
      end else if (wr_pend_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = wr_addr_ff;
         ram_wr_data = (ram_rd_data & ATTR_MASK) | CELL_W'(SPACE_CHAR);
      end else if (cmd.wr_put) begin
         ram_wr_en   = 1'b1;
         ram_wr_data = (ram_rd_data & ATTR_MASK) | CELL_W'(char_ff);
      end
   end

   tmcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         ptr_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         ptr_ff     <= ptr_in;
         wr_pend_ff <= cmd.sweep_step;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= ptr_ff[ADDR_W-1:0];
      if (cmd.latch_item) begin
         char_ff     <= req_char;
         in_range_ff <= req_in_range;
      end
      if (cmd.out_load) begin
         rsp_col_ff     <= COL_OUT_W'(col_in);
         rsp_row_ff     <= ROW_OUT_W'(row_in);
         rsp_cleared_ff <= (cmd.out_kind == OUT_CLEAR);
         rsp_cell_ff    <= ((cmd.out_kind == OUT_READ) && in_range_ff) ? ram_rd_data : '0;
      end
   end

   assign status.req_is_read      = (req_tuser[0] == OP_READ);
   assign status.req_char_zero    = (req_char == NUL_CHAR);
   assign status.req_char_newline = (req_char == NEWLINE_CHAR);
   assign status.last_row         = (row_ff == ROW_W'(ROWS - 1));
   assign status.last_col         = (col_ff == COL_W'(COLUMNS - 1));
   assign status.sweep_done       = (ptr_ff == CNT_W'(CELLS));
   assign status.rsp_free         = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_cell_ff, rsp_cleared_ff, rsp_row_ff, rsp_col_ff};

   `TMCW_ASSERT_NOW(a_one_writer, clock, reset, 1'b1,
      $onehot0({cmd.init_wr, wr_pend_ff, cmd.wr_put}), "two sources drive the cell write port")
   `TMCW_ASSERT_NOW(a_cursor_range, clock, reset, 1'b1,
      (({1'b0, col_ff} < (COL_W + 1)'(COLUMNS)) && ({1'b0, row_ff} < (ROW_W + 1)'(ROWS))),
      "cursor left the screen")
   `TMCW_ASSERT_NEXT(a_clear_homes, clock, reset,
      (cmd.out_load && (cmd.out_kind == OUT_CLEAR)),
      ((rsp_col_ff == '0) && (rsp_row_ff == '0) && rsp_cleared_ff),
      "screen clear result does not report a homed cursor")

endmodule

`default_nettype wire

/* design/tmcw_controller.sv */
// Controller of the console writer: sequences reads, puts, blanking and the clearing pass.
// Depends on tmcw_pkg and the shared assertion macros.
`default_nettype none
`include "text_mode_console_writer_defines.svh"

module tmcw_controller (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire tmcw_pkg::ctl_status_type status,
   output      tmcw_pkg::ctl_cmd_type    cmd
);

   import tmcw_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ,
      S_PUT,
      S_BLANK
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE) && status.rsp_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in         = state_ff;
      cmd.latch_item   = accept;
      cmd.rd_en        = 1'b0;
      cmd.rd_sel       = RD_CURSOR;
      cmd.cur_op       = CUR_HOLD;
      cmd.wr_put       = 1'b0;
      cmd.init_wr      = 1'b0;
      cmd.sweep_clear  = 1'b0;
      cmd.sweep_step   = 1'b0;
      cmd.out_load     = 1'b0;
      cmd.out_kind     = OUT_PUT;
      case (state_ff)
         S_INIT: begin
            if (status.sweep_done) begin
               cmd.sweep_clear = 1'b1;
               state_in        = S_IDLE;
            end else begin
               cmd.init_wr = 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (status.req_is_read) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_ITEM;
                  state_in   = S_READ;
               end else if (status.req_char_zero) begin
                  cmd.out_load = 1'b1;
               end else if (status.req_char_newline) begin
                  if (status.last_row) begin
                     cmd.cur_op      = CUR_HOME;
                     cmd.sweep_clear = 1'b1;
                     state_in        = S_BLANK;
                  end else begin
                     cmd.cur_op   = CUR_NEWLINE;
                     cmd.out_load = 1'b1;
                  end
               end else begin
                  // fetch the cell under the cursor to keep its attribute
                  cmd.rd_en = 1'b1;
                  state_in  = S_PUT;
               end
            end
         end
         S_READ: begin
            cmd.out_load = 1'b1;
            cmd.out_kind = OUT_READ;
            state_in     = S_IDLE;
         end
         S_PUT: begin
            cmd.wr_put = 1'b1;
            if (status.last_row && status.last_col) begin
               cmd.cur_op      = CUR_HOME;
               cmd.sweep_clear = 1'b1;
               state_in        = S_BLANK;
            end else begin
               cmd.cur_op   = CUR_ADVANCE;
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_BLANK: begin
            if (status.sweep_done) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_CLEAR;
               state_in     = S_IDLE;
            end else begin
               cmd.rd_en      = 1'b1;
               cmd.rd_sel     = RD_SWEEP;
               cmd.sweep_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   `TMCW_ASSERT_NOW(a_load_when_free, clock, reset, cmd.out_load, status.rsp_free,
      "result overwritten before it was taken")
   `TMCW_ASSERT_NOW(a_step_in_range, clock, reset, (cmd.sweep_step || cmd.init_wr),
      !status.sweep_done, "sweep ran past the last cell")
   `TMCW_ASSERT_NEXT(a_put_follows_fetch, clock, reset,
      (accept && !status.req_is_read && !status.req_char_zero && !status.req_char_newline),
      (state_ff == S_PUT), "character put did not wait for its cell fetch")

endmodule

`default_nettype wire

/* design/text_mode_console_writer.sv */
// Character-cell console writer: a ROWS by COLUMNS store of attribute/character cells.
// Request channel (req_) carries puts and reads; one result beat per request on rsp_.
// A put of a printable character rewrites the cell under the cursor and advances it.
// A newline moves to column 0 of the next row; passing the last row blanks all
// characters to spaces (attributes kept) and homes the cursor. A zero character
// changes nothing. A read returns one cell, or zero for an index off the screen.
// After reset a clearing pass writes every cell to grey blank; req_tready stays low
// until that pass is done.
// Timing: a read or a printable put loads the result register in the cycle after the
// request beat; a zero character, or a newline that does not blank the screen, loads
// it in the same cycle as the beat. A put that blanks the screen holds req_tready low
// through the read-modify-write sweep over the single cell RAM port pair.
// Items are handled one at a time.
// The result register frees the input side: a new request is taken while a result
// waits, as long as the receiver takes the pending beat in that cycle or it is empty;
// a stalled receiver holds rsp_tdata and, after that, req_tready.
// Depends on tmcw_pkg, tmcw_controller, tmcw_datapath and tmcw_ram.
`default_nettype none

module text_mode_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // [7:0] char_code, [18:8] cell_index, [23:19] zero
   input  wire logic [tmcw_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] opcode
   input  wire logic [tmcw_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [6:0] cursor_col, [11:7] cursor_row, [12] screen_cleared, [28:13] cell_data,
   // [31:29] zero
   output      logic [tmcw_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import tmcw_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   tmcw_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tmcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
